[hw/rtl/plfa_pkg.sv]
// package for the pixel lut fill alpha compositor
// holds sizes, codes, lane and control structs and the saturation helper
// no dependencies
package plfa_pkg;

  localparam int NUM_BANDS   = 3;
  localparam int IN_BITS     = 8;
  localparam int OUT_BITS    = 8;
  localparam int FIELD_BANDS = 3;
  localparam int TABLE_SIZE  = 1 << IN_BITS;

  localparam int PIX_W  = 8;
  localparam int BAND_W = 2;
  localparam int PROD_W = 2 * PIX_W;
  localparam int CFG_W  = 8;

  typedef logic [PIX_W-1:0]    pix_t;
  typedef logic [OUT_BITS-1:0] lut_t;
  typedef logic [IN_BITS-1:0]  idx_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [CFG_W-1:0]    cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_MAP   = 2'd1,
    MODE_FILL  = 2'd2,
    MODE_BLEND = 2'd3
  } plfa_mode_e;

  localparam cfg_idx_t CFG_FILL0 = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_FILL1 = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_FILL2 = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_TOL   = cfg_idx_t'(3);

  typedef struct packed {
    pix_t  lut;
    prod_t prod_dst;
    prod_t prod_lut;
    pix_t  dest;
  } plfa_lane_t;

  typedef struct packed {
    logic       valid;
    plfa_mode_e mode;
    logic       written;
  } plfa_ctrl_t;

  function automatic pix_t sat_lut(lut_t v);
    pix_t r;
    if (v > lut_t'(8'hFF)) begin
      r = 8'hFF;
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/plfa_if.sv]
// valid/ready channels of the compositor: pixel input, result output, config write
// depends on plfa_pkg
interface plfa_pix_if import plfa_pkg::*; ();
  logic  valid;
  logic  ready;
  logic [1:0] mode;
  logic [BAND_W-1:0] table_band;
  pix_t  table_value;
  pix_t  src_band0;
  pix_t  src_band1;
  pix_t  src_band2;
  pix_t  dest_band0;
  pix_t  dest_band1;
  pix_t  dest_band2;
  pix_t  alpha;

  modport source (output valid, mode, table_band, table_value, src_band0, src_band1,
                  src_band2, dest_band0, dest_band1, dest_band2, alpha, input ready);
  modport sink (input valid, mode, table_band, table_value, src_band0, src_band1,
                src_band2, dest_band0, dest_band1, dest_band2, alpha, output ready);
endinterface

interface plfa_res_if import plfa_pkg::*; ();
  logic valid;
  logic ready;
  pix_t out_band0;
  pix_t out_band1;
  pix_t out_band2;
  logic written;

  modport source (output valid, out_band0, out_band1, out_band2, written, input ready);
  modport sink (input valid, out_band0, out_band1, out_band2, written, output ready);
endinterface

interface plfa_cfg_if import plfa_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  pix_t     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/pixel_lut_fill_alpha_compositor.sv]
// an accepted pixel word passes the first and second lane registers and the merge output
// register; throughput: one pixel word per cycle unless the result output stalls; each
// band lane has its own table memory with one write and one registered read port per cycle
// table write words (mode 0) give no result word
// reset clears the pipeline valids and the fill registers; table contents are undefined
module pixel_lut_fill_alpha_compositor import plfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  plfa_pix_if.sink   pix_i,
  plfa_cfg_if.sink   cfg_i,
  plfa_res_if.source res_o
);

  pix_t fill_q [FIELD_BANDS];
  pix_t tol_q;
  logic v1_q;
  logic v1_d;
  plfa_mode_e mode1_q;
  pix_t alpha1_q;
  plfa_ctrl_t ctrl2_q;
  plfa_ctrl_t ctrl2_d;
  logic en1;
  logic en2;
  logic load;
  logic accept;
  plfa_mode_e mode_in;
  logic [FIELD_BANDS-1:0] exceed;
  plfa_lane_t lanes [FIELD_BANDS];
  pix_t src [FIELD_BANDS];
  pix_t dest [FIELD_BANDS];

  assign src[0]  = pix_i.src_band0;
  assign src[1]  = pix_i.src_band1;
  assign src[2]  = pix_i.src_band2;
  assign dest[0] = pix_i.dest_band0;
  assign dest[1] = pix_i.dest_band1;
  assign dest[2] = pix_i.dest_band2;

  assign mode_in = plfa_mode_e'(pix_i.mode);
  assign en2     = !ctrl2_q.valid || load;
  assign en1     = !v1_q || en2;
  assign accept  = pix_i.valid && en1;
  assign pix_i.ready = en1;
  assign cfg_i.ready = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '{default: '0};
      tol_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FILL0: fill_q[0] <= cfg_i.data;
        CFG_FILL1: fill_q[1] <= cfg_i.data;
        CFG_FILL2: fill_q[2] <= cfg_i.data;
        CFG_TOL:   tol_q     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // band lanes
  for (genvar b = 0; b < FIELD_BANDS; b++) begin : g_band
    if (b < NUM_BANDS) begin : g_lane
      logic we;
      assign we = accept && (mode_in == MODE_WRITE) && (pix_i.table_band == BAND_W'(b));
      plfa_lane u_lane (
        .clk_i    (clk_i),
        .en1_i    (en1),
        .en2_i    (en2),
        .we_i     (we),
        .waddr_i  (idx_t'(pix_i.src_band0)),
        .wdata_i  (lut_t'(pix_i.table_value)),
        .src_i    (src[b]),
        .dest_i   (dest[b]),
        .fill_i   (fill_q[b]),
        .tol_i    (tol_q),
        .alpha1_i (alpha1_q),
        .exceed_o (exceed[b]),
        .lane_o   (lanes[b])
      );
    end else begin : g_pass
      pix_t dest1_q;
      pix_t dest2_q;
      always_ff @(posedge clk_i) begin
        if (en1) begin
          dest1_q <= dest[b];
        end
        if (en2) begin
          dest2_q <= dest1_q;
        end
      end
      assign exceed[b] = 1'b0;
      assign lanes[b]  = '{lut: '0, prod_dst: '0, prod_lut: '0, dest: dest2_q};
    end
  end

  // control pipeline
  assign v1_d = en1 ? (pix_i.valid && (mode_in != MODE_WRITE)) : v1_q;

  always_comb begin
    ctrl2_d         = ctrl2_q;
    if (en2) begin
      ctrl2_d.valid   = v1_q;
      ctrl2_d.mode    = mode1_q;
      ctrl2_d.written = !((mode1_q == MODE_FILL) && !(|exceed));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      ctrl2_q <= '0;
    end else begin
      v1_q    <= v1_d;
      ctrl2_q <= ctrl2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mode1_q  <= mode_in;
      alpha1_q <= pix_i.alpha;
    end
  end

  plfa_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl2_q),
    .lanes_i (lanes),
    .load_o  (load),
    .res_o   (res_o)
  );

  a_map_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_in != MODE_WRITE)) |=> v1_q)
    else $error("mapped word did not enter the pipeline");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_in == MODE_WRITE)) |=> !v1_q)
    else $error("table write word entered the result pipeline");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en1 |-> (v1_q && ctrl2_q.valid && res_o.valid && !res_o.ready))
    else $error("input stalled while the pipeline had room");

  a_unwritten_only_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl2_q.valid && !ctrl2_q.written) |-> (ctrl2_q.mode == MODE_FILL))
    else $error("fill result outside fill-keyed mode");

endmodule

[hw/rtl/plfa_lane.sv]
// one band lane: lookup table memory, fill check and blend products
// depends on plfa_pkg
module plfa_lane import plfa_pkg::*; (
  input  logic       clk_i,
  input  logic       en1_i,
  input  logic       en2_i,
  input  logic       we_i,
  input  idx_t       waddr_i,
  input  lut_t       wdata_i,
  input  pix_t       src_i,
  input  pix_t       dest_i,
  input  pix_t       fill_i,
  input  pix_t       tol_i,
  input  pix_t       alpha1_i,
  output logic       exceed_o,
  output plfa_lane_t lane_o
);

  lut_t tbl_mem [TABLE_SIZE];
  lut_t rdata_q;
  pix_t dest1_q;
  logic exceed_q;
  plfa_lane_t lane_q;
  plfa_lane_t lane_d;
  pix_t diff;
  pix_t lut_sat;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      tbl_mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      rdata_q <= tbl_mem[idx_t'(src_i)];
    end
  end

  always_comb begin
    diff = (src_i > fill_i) ? src_i - fill_i : fill_i - src_i;
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      dest1_q  <= dest_i;
      exceed_q <= diff > tol_i;
    end
  end

  always_comb begin
    lut_sat         = sat_lut(rdata_q);
    lane_d.lut      = lut_sat;
    lane_d.prod_dst = prod_t'(dest1_q) * prod_t'(8'hFF - alpha1_i);
    lane_d.prod_lut = prod_t'(lut_sat) * prod_t'(alpha1_i);
    lane_d.dest     = dest1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      lane_q <= lane_d;
    end
  end

  assign exceed_o = exceed_q;
  assign lane_o   = lane_q;

endmodule

[hw/rtl/plfa_merge.sv]
// merge stage: sums lane products, divides by 255, selects per mode, output register
// depends on plfa_pkg and plfa_if
module plfa_merge import plfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plfa_ctrl_t        ctrl_i,
  input  plfa_lane_t        lanes_i [FIELD_BANDS],
  output logic              load_o,
  plfa_res_if.source        res_o
);

  logic ov_q;
  logic ov_d;
  pix_t band_q [FIELD_BANDS];
  pix_t band_d [FIELD_BANDS];
  logic written_q;
  logic [PROD_W:0] sum [FIELD_BANDS];
  logic [PROD_W:0] rnd [FIELD_BANDS];
  logic [PIX_W:0]  quo [FIELD_BANDS];
  pix_t blend [FIELD_BANDS];

  assign load_o = !ov_q || res_o.ready;
  assign ov_d   = load_o ? ctrl_i.valid : ov_q;

  always_comb begin
    for (int b = 0; b < FIELD_BANDS; b++) begin
      sum[b] = {1'b0, lanes_i[b].prod_dst} + {1'b0, lanes_i[b].prod_lut};
      // x / 255 as (x + (x >> 8) + 1) >> 8, exact for x up to 255 * 255
      rnd[b] = {1'b0, sum[b][PROD_W-1:0]} + (PROD_W+1)'(sum[b][PROD_W-1:PIX_W])
               + (PROD_W+1)'(1);
      quo[b] = rnd[b][PROD_W:PIX_W];
      blend[b] = quo[b][PIX_W] ? 8'hFF : quo[b][PIX_W-1:0];
      if (b >= NUM_BANDS || !ctrl_i.written) begin
        band_d[b] = lanes_i[b].dest;
      end else if (ctrl_i.mode == MODE_BLEND) begin
        band_d[b] = blend[b];
      end else begin
        band_d[b] = lanes_i[b].lut;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o && ctrl_i.valid) begin
      band_q    <= band_d;
      written_q <= ctrl_i.written;
    end
  end

  assign res_o.valid     = ov_q;
  assign res_o.out_band0 = band_q[0];
  assign res_o.out_band1 = band_q[1];
  assign res_o.out_band2 = band_q[2];
  assign res_o.written   = written_q;

endmodule

[bench/plfa_result_checker.sv]
`timescale 1ns / 100ps
// result checker for the pixel lut fill alpha compositor: predicts every non-write pixel word
// and compares the result words field by field; depends on plfa_pkg and plfa_if
module plfa_result_checker import plfa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  plfa_pix_if  pix_i,
  plfa_cfg_if  cfg_i,
  plfa_res_if  res_i,
  output int   fail_cnt_o,
  output int   pending_o
);

  typedef pix_t [FIELD_BANDS-1:0] band_vec_t;

  typedef struct packed {
    pix_t band0;
    pix_t band1;
    pix_t band2;
    logic written;
  } composite_t;

  lut_t       lut_mem [NUM_BANDS][TABLE_SIZE];
  pix_t       fill_ref [FIELD_BANDS];
  pix_t       tol_ref;
  composite_t composite_q [$];

  function automatic composite_t composite_pixel(plfa_mode_e m, band_vec_t src,
                                                 band_vec_t dst, pix_t a);
    band_vec_t o;
    logic      keep;
    int        diff;
    int        acc;
    pix_t      mapped;
    keep = 1'b0;
    if (m == MODE_FILL) begin
      keep = 1'b1;
      for (int b = 0; b < NUM_BANDS; b++) begin
        diff = int'(src[b]) - int'(fill_ref[b]);
        if (diff < 0) begin
          diff = -diff;
        end
        if (diff > int'(tol_ref)) begin
          keep = 1'b0;
        end
      end
    end
    for (int b = 0; b < FIELD_BANDS; b++) begin
      o[b] = dst[b];
      if (b < NUM_BANDS && !keep) begin
        mapped = (lut_mem[b][src[b]] > 8'hFF) ? 8'hFF : pix_t'(lut_mem[b][src[b]]);
        if (m == MODE_BLEND) begin
          acc = (int'(dst[b]) * (255 - int'(a)) + int'(mapped) * int'(a)) / 255;
          o[b] = (acc > 255) ? 8'hFF : pix_t'(acc);
        end else begin
          o[b] = mapped;
        end
      end
    end
    return {o[0], o[1], o[2], ~keep};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    composite_t got;
    composite_t want;
    plfa_mode_e m;
    if (!rst_ni) begin
      composite_q.delete();
      for (int b = 0; b < FIELD_BANDS; b++) begin
        fill_ref[b] = '0;
      end
      tol_ref = '0;
      pending_o = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got = {res_i.out_band0, res_i.out_band1, res_i.out_band2, res_i.written};
        if (composite_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10) begin
            $display("%0t: result word with no pixel pending: %h %h %h written=%b",
                     $time, got.band0, got.band1, got.band2, got.written);
          end
        end else begin
          want = composite_q.pop_front();
          if (got.band0 !== want.band0 || got.band1 !== want.band1 ||
              got.band2 !== want.band2 || got.written !== want.written) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10) begin
              $display("%0t: mismatch expected %h %h %h written=%b, got %h %h %h written=%b",
                       $time, want.band0, want.band1, want.band2, want.written,
                       got.band0, got.band1, got.band2, got.written);
            end
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_FILL0: fill_ref[0] = cfg_i.data;
          CFG_FILL1: fill_ref[1] = cfg_i.data;
          CFG_FILL2: fill_ref[2] = cfg_i.data;
          CFG_TOL:   tol_ref = cfg_i.data;
          default: ;
        endcase
      end
      if (pix_i.valid && pix_i.ready) begin
        m = plfa_mode_e'(pix_i.mode);
        if (m == MODE_WRITE) begin
          if (pix_i.table_band < NUM_BANDS) begin
            lut_mem[pix_i.table_band][pix_i.src_band0] = pix_i.table_value;
          end
        end else begin
          composite_q = {composite_q, composite_pixel(m,
            {pix_i.src_band2, pix_i.src_band1, pix_i.src_band0},
            {pix_i.dest_band2, pix_i.dest_band1, pix_i.dest_band0}, pix_i.alpha)};
        end
      end
      pending_o = composite_q.size();
    end
  end

endmodule

[bench/tb_pixel_lut_fill_alpha_compositor.sv]
`timescale 1ns / 100ps
// testbench top for the pixel lut fill alpha compositor: drives pixel and config
// words, stalls result words and gives the verdict; depends on plfa_pkg, plfa_if,
// the compositor and plfa_result_checker
module tb_pixel_lut_fill_alpha_compositor;
  import plfa_pkg::*;

  typedef struct packed {
    plfa_mode_e        mode;
    logic [BAND_W-1:0] table_band;
    pix_t              table_value;
    pix_t              src0;
    pix_t              src1;
    pix_t              src2;
    pix_t              dest0;
    pix_t              dest1;
    pix_t              dest2;
    pix_t              alpha;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst_n;
  int   send_gap_pct;
  int   recv_gap_pct;
  int   hold_req_id;
  int   hold_len;
  int   fail_cnt;
  int   pend_cnt;
  pix_t fill_now [FIELD_BANDS];
  pix_t tol_now;

  plfa_pix_if pix ();
  plfa_res_if res ();
  plfa_cfg_if cfg ();

  pixel_lut_fill_alpha_compositor DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  plfa_result_checker CHK (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .pix_i      (pix),
    .cfg_i      (cfg),
    .res_i      (res),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pend_cnt)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic pixel_word_t pixel_word(plfa_mode_e m, logic [BAND_W-1:0] tb,
                                             pix_t tv, pix_t s0, pix_t s1, pix_t s2,
                                             pix_t d0, pix_t d1, pix_t d2, pix_t a);
    return '{m, tb, tv, s0, s1, s2, d0, d1, d2, a};
  endfunction

  // value around a fill value, mostly within the tolerance
  function automatic pix_t near_fill(pix_t f);
    int span;
    int v;
    span = int'(tol_now) + (($urandom_range(2) == 0) ? 2 : 0);
    v = int'(f) + int'($urandom_range(2 * span)) - span;
    if (v < 0) begin
      v = 0;
    end else if (v > 255) begin
      v = 255;
    end
    return pix_t'(v);
  endfunction

  function automatic pixel_word_t random_word();
    pixel_word_t w;
    int pick;
    pick = $urandom_range(99);
    w.mode = (pick < 15) ? MODE_WRITE : (pick < 40) ? MODE_MAP :
             (pick < 75) ? MODE_FILL : MODE_BLEND;
    w.table_band  = BAND_W'($urandom_range(3));
    w.table_value = pix_t'($urandom_range(255));
    w.src0  = pix_t'($urandom_range(255));
    w.src1  = pix_t'($urandom_range(255));
    w.src2  = pix_t'($urandom_range(255));
    w.dest0 = pix_t'($urandom_range(255));
    w.dest1 = pix_t'($urandom_range(255));
    w.dest2 = pix_t'($urandom_range(255));
    w.alpha = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                       : pix_t'($urandom_range(255));
    if (w.mode == MODE_FILL && $urandom_range(3) != 0) begin
      w.src0 = near_fill(fill_now[0]);
      w.src1 = near_fill(fill_now[1]);
      w.src2 = near_fill(fill_now[2]);
    end
    return w;
  endfunction

  task automatic set_payload(pixel_word_t w);
    pix.mode        <= w.mode;
    pix.table_band  <= w.table_band;
    pix.table_value <= w.table_value;
    pix.src_band0   <= w.src0;
    pix.src_band1   <= w.src1;
    pix.src_band2   <= w.src2;
    pix.dest_band0  <= w.dest0;
    pix.dest_band1  <= w.dest1;
    pix.dest_band2  <= w.dest2;
    pix.alpha       <= w.alpha;
  endtask

  task automatic send_word(pixel_word_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    set_payload(w);
    @(posedge clk);
    while (!pix.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic random_run(int n);
    repeat (n) begin
      send_word(random_word());
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, pix_t val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic program_fill(pix_t f0, pix_t f1, pix_t f2, pix_t tol);
    write_reg(CFG_FILL0, f0);
    write_reg(CFG_FILL1, f1);
    write_reg(CFG_FILL2, f2);
    write_reg(CFG_TOL, tol);
    cfg.valid <= 1'b0;
    fill_now[0] = f0;
    fill_now[1] = f1;
    fill_now[2] = f2;
    tol_now = tol;
  endtask

  // wait until every result word is in, then let table writes retire
  task automatic settle();
    pix.valid <= 1'b0;
    do @(negedge clk); while (pend_cnt != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin : result_drain
    int hold_left;
    int seen_id;
    hold_left = 0;
    seen_id = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_id != seen_id) begin
        seen_id = hold_req_id;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  initial begin : stimulus
    rst_n        <= 1'b0;
    pix.valid    <= 1'b0;
    set_payload('0);
    cfg.valid    <= 1'b0;
    cfg.index    <= CFG_FILL0;
    cfg.data     <= '0;
    send_gap_pct <= 0;
    recv_gap_pct <= 0;
    hold_req_id  <= 0;
    hold_len     <= 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_fill(8'h10, 8'hC8, 8'hFF, 8'h05);
    send_gap_pct <= 7;
    recv_gap_pct <= 86;

    // every table entry gets written before any lookup
    for (int b = 0; b < NUM_BANDS; b++) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        send_word(pixel_word(MODE_WRITE, BAND_W'(b), pix_t'($urandom_range(255)),
                             pix_t'(i), '0, '0, '0, '0, '0, '0));
      end
    end

    send_word(pixel_word(MODE_WRITE, 2'd0, 8'hFF, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0));
    send_word(pixel_word(MODE_WRITE, 2'd1, 8'h00, 8'hFF, 8'h00, 8'h00, 0, 0, 0, 0));
    send_word(pixel_word(MODE_WRITE, 2'd2, 8'hFF, 8'h80, 8'h00, 8'h00, 0, 0, 0, 0));
    // out of range band, must leave band 0 alone
    send_word(pixel_word(MODE_WRITE, 2'd3, 8'h00, 8'h00, 8'hFF, 8'hFF,
                         8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(pixel_word(MODE_MAP, 2'd0, 0, 8'h00, 8'hFF, 8'h80, 8'h12, 8'h34, 8'h56, 0));
    send_word(pixel_word(MODE_MAP, 2'd0, 0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0));
    // fill key: exact, within tolerance, just outside on each band and below
    send_word(pixel_word(MODE_FILL, 2'd0, 0, 8'h10, 8'hC8, 8'hFF, 8'hAA, 8'hBB, 8'hCC, 0));
    send_word(pixel_word(MODE_FILL, 2'd0, 0, 8'h15, 8'hC3, 8'hFA, 8'h01, 8'h02, 8'h03, 0));
    send_word(pixel_word(MODE_FILL, 2'd0, 0, 8'h16, 8'hC8, 8'hFF, 8'hAA, 8'hBB, 8'hCC, 0));
    send_word(pixel_word(MODE_FILL, 2'd0, 0, 8'h10, 8'hCE, 8'hFF, 8'hAA, 8'hBB, 8'hCC, 0));
    send_word(pixel_word(MODE_FILL, 2'd0, 0, 8'h10, 8'hC8, 8'hF9, 8'hAA, 8'hBB, 8'hCC, 0));
    send_word(pixel_word(MODE_FILL, 2'd0, 0, 8'h0A, 8'hC8, 8'hFF, 8'hAA, 8'hBB, 8'hCC, 0));
    send_word(pixel_word(MODE_BLEND, 2'd0, 0, 8'h00, 8'hFF, 8'h80, 8'h12, 8'h34, 8'h56,
                         8'h00));
    send_word(pixel_word(MODE_BLEND, 2'd0, 0, 8'h00, 8'hFF, 8'h80, 8'h12, 8'h34, 8'h56,
                         8'hFF));
    send_word(pixel_word(MODE_BLEND, 2'd0, 0, 8'h00, 8'hFF, 8'h80, 8'hFF, 8'hFF, 8'h00,
                         8'h80));
    send_word(pixel_word(MODE_BLEND, 2'd0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h80,
                         8'h01));
    send_word(pixel_word(MODE_MAP, 2'd0, 0, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hFF, 8'hFF, 0));

    settle();
    program_fill(8'h00, 8'h00, 8'h00, 8'h00);
    random_run(10);

    settle();
    program_fill(pix_t'($urandom_range(255)), pix_t'($urandom_range(255)),
                 pix_t'($urandom_range(255)), pix_t'($urandom_range(12)));
    random_run(10);

    settle();
    send_gap_pct <= 86;
    recv_gap_pct <= 7;
    program_fill(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    random_run(10);

    settle();
    program_fill(pix_t'($urandom_range(255)), pix_t'($urandom_range(255)),
                 pix_t'($urandom_range(255)), pix_t'($urandom_range(12)));
    random_run(10);

    settle();
    send_gap_pct <= 0;
    recv_gap_pct <= 0;
    program_fill(8'hFF, 8'h00, 8'h80, 8'h03);
    // long result stall while words keep coming
    hold_len    <= 300;
    hold_req_id <= hold_req_id + 1;
    random_run(30);

    settle();
    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
